FILE: design/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher block.
// Holds the transaction payloads, controller states, and the command and
// status structs between the controller and the datapath. No dependencies.
`default_nettype none

package rc4_pkg;

   // Permutation and byte geometry
   localparam int BYTE_W            = 8;
   localparam int SBOX_DEPTH        = 256;
   localparam int SBOX_AW           = $clog2(SBOX_DEPTH);
   localparam int DEF_MAX_KEY_BYTES = 256;

   // Item kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [SBOX_AW-1:0] sbox_addr_type;

   typedef struct packed {
      logic     kind;
      byte_type key_byte;
      logic     key_last;
      byte_type data_byte;
      logic     block_end;
   } req_item_type;

   typedef struct packed {
      byte_type out_byte;
      logic     block_end_out;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DATA_FETCH_J,
      ST_DATA_SWAP_I,
      ST_DATA_SWAP_J,
      ST_DATA_KS,
      ST_DATA_OUT,
      ST_SCHED_READ,
      ST_SCHED_ACC,
      ST_SCHED_SWAP_N,
      ST_SCHED_SWAP_ACC
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic take_key;
      logic sched_start;
      logic take_data;
      logic data_fetch_j;
      logic data_swap_i;
      logic data_swap_j;
      logic data_ks;
      logic load_out;
      logic sched_read;
      logic sched_acc;
      logic sched_swap_n;
      logic sched_swap_acc;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic sched_last;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: design/rc4_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on rc4_pkg for the payload types.
`default_nettype none

interface rc4_req_if;
   logic                  valid;
   logic                  ready;
   rc4_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rc4_rsp_if;
   logic                  valid;
   logic                  ready;
   rc4_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/rc4_ctrl.sv
// Controller state machine of the RC4 block: sequences data bytes and the
// key schedule rounds. Depends on rc4_pkg for states, commands and status.
`default_nettype none

module rc4_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_kind,
   input  wire logic                     req_key_last,
   input  wire rc4_pkg::ctrl_status_type status,
   output rc4_pkg::ctrl_cmd_type         cmd
);

   rc4_pkg::ctrl_state_type state_ff;
   rc4_pkg::ctrl_state_type state_in;
   logic                    take;

   assign take = req_valid && (state_ff == rc4_pkg::ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (take) begin
               if (req_kind == rc4_pkg::KIND_DATA) begin
                  state_in = rc4_pkg::ST_DATA_FETCH_J;
               end else if (req_key_last) begin
                  state_in = rc4_pkg::ST_SCHED_READ;
               end
            end
         end
         rc4_pkg::ST_DATA_FETCH_J:   state_in = rc4_pkg::ST_DATA_SWAP_I;
         rc4_pkg::ST_DATA_SWAP_I:    state_in = rc4_pkg::ST_DATA_SWAP_J;
         rc4_pkg::ST_DATA_SWAP_J:    state_in = rc4_pkg::ST_DATA_KS;
         rc4_pkg::ST_DATA_KS:        state_in = rc4_pkg::ST_DATA_OUT;
         rc4_pkg::ST_DATA_OUT: begin
            if (status.out_free) begin
               state_in = rc4_pkg::ST_IDLE;
            end
         end
         rc4_pkg::ST_SCHED_READ:     state_in = rc4_pkg::ST_SCHED_ACC;
         rc4_pkg::ST_SCHED_ACC:      state_in = rc4_pkg::ST_SCHED_SWAP_N;
         rc4_pkg::ST_SCHED_SWAP_N:   state_in = rc4_pkg::ST_SCHED_SWAP_ACC;
         rc4_pkg::ST_SCHED_SWAP_ACC: begin
            state_in = status.sched_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_SCHED_READ;
         end
         default:                    state_in = rc4_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            cmd.req_ready   = 1'b1;
            cmd.take_key    = take && (req_kind == rc4_pkg::KIND_KEY);
            cmd.sched_start = take && (req_kind == rc4_pkg::KIND_KEY) && req_key_last;
            cmd.take_data   = take && (req_kind == rc4_pkg::KIND_DATA);
         end
         rc4_pkg::ST_DATA_FETCH_J:   cmd.data_fetch_j   = 1'b1;
         rc4_pkg::ST_DATA_SWAP_I:    cmd.data_swap_i    = 1'b1;
         rc4_pkg::ST_DATA_SWAP_J:    cmd.data_swap_j    = 1'b1;
         rc4_pkg::ST_DATA_KS:        cmd.data_ks        = 1'b1;
         rc4_pkg::ST_DATA_OUT:       cmd.load_out       = status.out_free;
         rc4_pkg::ST_SCHED_READ:     cmd.sched_read     = 1'b1;
         rc4_pkg::ST_SCHED_ACC:      cmd.sched_acc      = 1'b1;
         rc4_pkg::ST_SCHED_SWAP_N:   cmd.sched_swap_n   = 1'b1;
         rc4_pkg::ST_SCHED_SWAP_ACC: cmd.sched_swap_acc = 1'b1;
         default:                    cmd = '0;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rc4_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/rc4_datapath.sv
// Datapath of the RC4 block: permutation memory with per-entry valid bits,
// key buffer, indices, and the response output register.
// Depends on rc4_pkg for payload, command and status types.
`default_nettype none

module rc4_datapath #(
   parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rc4_pkg::ctrl_cmd_type    cmd,
   output rc4_pkg::ctrl_status_type      status,
   input  wire rc4_pkg::req_item_type    req_item,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output rc4_pkg::rsp_item_type         rsp_item
);

   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int EXT_W  = CNT_W + 1;

   // Permutation memory and its read port
   rc4_pkg::byte_type              sbox_mem [rc4_pkg::SBOX_DEPTH];
   logic [rc4_pkg::SBOX_DEPTH-1:0] sbox_vld_ff;
   rc4_pkg::byte_type              sbox_rd_ff;
   rc4_pkg::sbox_addr_type         sbox_raddr_ff;
   logic                           sbox_rd_vld_ff;
   rc4_pkg::byte_type              rd_val;

   logic                           sbox_re;
   rc4_pkg::sbox_addr_type         sbox_raddr;
   logic                           sbox_we;
   rc4_pkg::sbox_addr_type         sbox_waddr;
   rc4_pkg::byte_type              sbox_wdata;

   // Indices and working values
   rc4_pkg::sbox_addr_type         first_index_ff;
   rc4_pkg::sbox_addr_type         first_index_in;
   rc4_pkg::sbox_addr_type         second_index_ff;
   rc4_pkg::sbox_addr_type         second_index_in;
   rc4_pkg::sbox_addr_type         acc_ff;
   rc4_pkg::sbox_addr_type         acc_in;
   rc4_pkg::byte_type              a_ff;
   rc4_pkg::byte_type              b_ff;
   rc4_pkg::sbox_addr_type         j_sum;
   rc4_pkg::sbox_addr_type         acc_sum;
   rc4_pkg::byte_type              data_ff;
   logic                           block_end_ff;

   // Key buffer
   rc4_pkg::byte_type              key_mem [MAX_KEY_BYTES];
   rc4_pkg::byte_type              key_rd_ff;
   logic [CNT_W-1:0]               key_count_ff;
   logic [CNT_W-1:0]               key_count_in;
   logic [CNT_W-1:0]               key_len_ff;
   logic [KIDX_W-1:0]              kidx_ff;
   logic [KIDX_W-1:0]              kidx_in;
   logic [EXT_W-1:0]               kidx_next;
   logic                           key_full;

   // Output register
   logic                           out_valid_ff;
   rc4_pkg::rsp_item_type          out_item_ff;

   // An entry not written since the last schedule holds its own index
   assign rd_val  = sbox_rd_vld_ff ? sbox_rd_ff : rc4_pkg::BYTE_W'(sbox_raddr_ff);
   assign j_sum   = second_index_ff + rc4_pkg::SBOX_AW'(rd_val);
   assign acc_sum = acc_ff + rc4_pkg::SBOX_AW'(rd_val) + rc4_pkg::SBOX_AW'(key_rd_ff);

   assign key_full  = (key_count_ff == CNT_W'(MAX_KEY_BYTES));
   assign kidx_next = EXT_W'(kidx_ff) + EXT_W'(1);

   // Select the permutation read and write for this step
   always_comb begin
      sbox_re    = 1'b0;
      sbox_raddr = first_index_ff;
      sbox_we    = 1'b0;
      sbox_waddr = first_index_ff;
      sbox_wdata = rd_val;
      if (cmd.take_data) begin
         sbox_re    = 1'b1;
         sbox_raddr = first_index_ff + rc4_pkg::SBOX_AW'(1);
      end else if (cmd.data_fetch_j) begin
         sbox_re    = 1'b1;
         sbox_raddr = j_sum;
      end else if (cmd.data_swap_i) begin
         sbox_we    = 1'b1;
         sbox_waddr = first_index_ff;
         sbox_wdata = rd_val;
      end else if (cmd.data_swap_j) begin
         sbox_we    = 1'b1;
         sbox_waddr = second_index_ff;
         sbox_wdata = a_ff;
      end else if (cmd.data_ks) begin
         sbox_re    = 1'b1;
         sbox_raddr = rc4_pkg::SBOX_AW'(a_ff + b_ff);
      end else if (cmd.sched_read) begin
         sbox_re    = 1'b1;
         sbox_raddr = first_index_ff;
      end else if (cmd.sched_acc) begin
         sbox_re    = 1'b1;
         sbox_raddr = acc_sum;
      end else if (cmd.sched_swap_n) begin
         sbox_we    = 1'b1;
         sbox_waddr = first_index_ff;
         sbox_wdata = rd_val;
      end else if (cmd.sched_swap_acc) begin
         sbox_we    = 1'b1;
         sbox_waddr = acc_ff;
         sbox_wdata = a_ff;
      end
   end

   // Permutation memory
   always_ff @(posedge clock) begin
      if (sbox_we) begin
         sbox_mem[sbox_waddr] <= sbox_wdata;
      end
      if (sbox_re) begin
         sbox_rd_ff    <= sbox_mem[sbox_raddr];
         sbox_raddr_ff <= sbox_raddr;
      end
   end

   // Valid bits: drop all at schedule start, mark each entry as written
   always_ff @(posedge clock) begin
      if (reset) begin
         sbox_vld_ff    <= '0;
         sbox_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.sched_start) begin
            sbox_vld_ff <= '0;
         end else if (sbox_we) begin
            sbox_vld_ff[sbox_waddr] <= 1'b1;
         end
         if (sbox_re) begin
            sbox_rd_vld_ff <= sbox_vld_ff[sbox_raddr];
         end
      end
   end

   // Next index values
   always_comb begin
      first_index_in  = first_index_ff;
      second_index_in = second_index_ff;
      acc_in          = acc_ff;
      if (cmd.sched_start) begin
         first_index_in  = '0;
         second_index_in = '0;
         acc_in          = '0;
      end
      if (cmd.take_data || cmd.sched_swap_acc) begin
         first_index_in = first_index_ff + rc4_pkg::SBOX_AW'(1);
      end
      if (cmd.data_fetch_j) begin
         second_index_in = j_sum;
      end
      if (cmd.sched_acc) begin
         acc_in = acc_sum;
      end
   end

   // Hold indices
   always_ff @(posedge clock) begin
      if (reset) begin
         first_index_ff  <= '0;
         second_index_ff <= '0;
      end else begin
         first_index_ff  <= first_index_in;
         second_index_ff <= second_index_in;
      end
   end

   // Working values and the pending data transaction
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.data_fetch_j || cmd.sched_acc) begin
         a_ff <= rd_val;
      end
      if (cmd.data_swap_i) begin
         b_ff <= rd_val;
      end
      if (cmd.take_data) begin
         data_ff      <= req_item.data_byte;
         block_end_ff <= req_item.block_end;
      end
   end

   // Key count: advance per stored byte, clear when the schedule starts
   always_comb begin
      key_count_in = key_count_ff;
      if (cmd.sched_start) begin
         key_count_in = '0;
      end else if (cmd.take_key && !key_full) begin
         key_count_in = key_count_ff + CNT_W'(1);
      end
   end

   // Key position: cycle through the stored key
   always_comb begin
      kidx_in = kidx_ff;
      if (cmd.sched_start) begin
         kidx_in = '0;
      end else if (cmd.sched_swap_acc) begin
         if (kidx_next == EXT_W'(key_len_ff)) begin
            kidx_in = '0;
         end else begin
            kidx_in = kidx_next[KIDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   // Key buffer; bytes beyond its depth are dropped
   always_ff @(posedge clock) begin
      kidx_ff <= kidx_in;
      if (cmd.take_key && !key_full) begin
         key_mem[key_count_ff[KIDX_W-1:0]] <= req_item.key_byte;
      end
      if (cmd.sched_start) begin
         key_len_ff <= key_full ? key_count_ff : key_count_ff + CNT_W'(1);
      end
      if (cmd.sched_read) begin
         key_rd_ff <= key_mem[kidx_ff];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_item_ff.out_byte      <= data_ff ^ rd_val;
         out_item_ff.block_end_out <= block_end_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_item          = out_item_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.sched_last = (first_index_ff == rc4_pkg::SBOX_AW'(rc4_pkg::SBOX_DEPTH - 1));

endmodule

`default_nettype wire

FILE: design/rc4_stream_cipher.sv
// RC4 stream cipher, one transaction at a time. The key byte transaction
// with key_last also runs the key schedule: 256 rounds of read, accumulate
// and two writes on the single write port of the permutation memory, and the
// next transaction is taken only when the schedule ends. A data byte
// transaction runs through the accept with the first permutation read, the
// second dependent read, two swap writes, the keystream read and the load of
// the output register, all on the one permutation memory. Its response goes
// to an output register, so the next transaction is taken while the response
// waits; the load stalls only while an earlier response is still held there.
// The permutation needs no clearing pass: valid bits restore identity at
// reset and at each schedule start.
// Depends on rc4_pkg, rc4_if, rc4_ctrl and rc4_datapath.
`default_nettype none

module rc4_stream_cipher #(
   parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rc4_req_if.sink     req_chan,
   rc4_rsp_if.source   rsp_chan
);

   rc4_pkg::ctrl_cmd_type    cmd;
   rc4_pkg::ctrl_status_type status;

   // Sequence the work
   rc4_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_kind     (req_chan.payload.kind),
      .req_key_last (req_chan.payload.key_last),
      .status       (status),
      .cmd          (cmd)
   );

   // Permutation, key buffer and response register
   rc4_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_item  (rsp_chan.payload)
   );

   assign req_chan.ready = cmd.req_ready;

endmodule

`default_nettype wire

FILE: tb/sv/rc4_stream_cipher_tb.sv
// Self-checking testbench for the RC4 stream cipher block.
// Sends key and data transactions, predicts each response from its own cipher state
// and compares it. Depends on rc4_pkg, rc4_if and rc4_stream_cipher.
module rc4_stream_cipher_tb;
   import rc4_pkg::*;

   localparam int KEY_CAP       = DEF_MAX_KEY_BYTES;
   localparam int IDLE_LIMIT    = 10000;
   localparam int ITEM_TARGET   = 1450;
   localparam int SETTLE_CYCLES = 1100;
   localparam int REPORT_CAP    = 10;
   localparam int LONG_HOLD     = 400;

   logic clock;
   logic reset;

   rc4_req_if req_chan ();
   rc4_rsp_if rsp_chan ();

   rc4_stream_cipher u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted cipher state
   byte_type   perm [SBOX_DEPTH];
   byte_type   ptr_i;
   byte_type   ptr_j;
   byte_type   key_buf [KEY_CAP];
   logic [8:0] key_len;

   // Ciphertext bytes still owed by the block, oldest first
   rsp_item_type cipher_q [$];

   int items_sent    = 0;
   int key_items     = 0;
   int data_items    = 0;
   int schedules_run = 0;
   int results_seen  = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   bit req_gaps_on     = 1'b1;
   bit rsp_gaps_on     = 1'b1;
   int rsp_hold_cycles = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_CAP) $display("%s", msg);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void perm_swap(input byte_type a, input byte_type b);
      byte_type t;
      t       = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
   endfunction

   function automatic void perm_identity();
      for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = byte_type'(n);
      ptr_i = '0;
      ptr_j = '0;
   endfunction

   // Rebuild the permutation from the collected key, cycling it by its length
   function automatic void run_key_schedule();
      int       len;
      byte_type acc;
      len = (key_len == 0) ? 1 : int'(key_len);
      perm_identity();
      acc = '0;
      for (int n = 0; n < SBOX_DEPTH; n++) begin
         acc = acc + perm[n] + key_buf[n % len];
         perm_swap(byte_type'(n), acc);
      end
      key_len = '0;
      schedules_run++;
   endfunction

   // Advance the predicted state by one accepted transaction
   function automatic void rc4_advance(input req_item_type it);
      rsp_item_type res;
      byte_type     ks_addr;
      if (it.kind == KIND_KEY) begin
         key_items++;
         // drop key bytes once the buffer is full
         if (key_len < KEY_CAP) begin
            key_buf[key_len] = it.key_byte;
            key_len++;
         end
         if (it.key_last) run_key_schedule();
      end else begin
         data_items++;
         ptr_i = ptr_i + 8'd1;
         ptr_j = ptr_j + perm[ptr_i];
         perm_swap(ptr_i, ptr_j);
         ks_addr           = perm[ptr_i] + perm[ptr_j];
         res.out_byte      = it.data_byte ^ perm[ks_addr];
         res.block_end_out = it.block_end;
         cipher_q.push_back(res);
      end
   endfunction

   // Unused fields carry random values so that every bit toggles
   function automatic req_item_type key_item(input byte_type kb, input logic last);
      req_item_type it;
      it.kind      = KIND_KEY;
      it.key_byte  = kb;
      it.key_last  = last;
      it.data_byte = byte_type'($urandom);
      it.block_end = 1'($urandom);
      return it;
   endfunction

   function automatic req_item_type data_item(input byte_type db, input logic bend);
      req_item_type it;
      it.kind      = KIND_DATA;
      it.key_byte  = byte_type'($urandom);
      it.key_last  = 1'($urandom);
      it.data_byte = db;
      it.block_end = bend;
      return it;
   endfunction

   // Offer one transaction and hold it until the block takes it
   task automatic send_item(input req_item_type it);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      rc4_advance(it);
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_key(input int len, input bit with_last, input bit noisy);
      for (int k = 0; k < len; k++) begin
         // stray data byte in the middle of a key
         if (noisy && $urandom_range(0, 99) < 8)
            send_item(data_item(byte_type'($urandom), 1'($urandom)));
         send_item(key_item(byte_type'($urandom), with_last && (k == len - 1)));
      end
   endtask

   task automatic send_data_run(input int len);
      for (int k = 0; k < len; k++)
         send_item(data_item(byte_type'($urandom),
                             (k == len - 1) || ($urandom_range(0, 9) == 0)));
   endtask

   // Tests

   task automatic test_data_before_key();
      send_item(data_item(8'h00, 1'b0));
      send_item(data_item(8'hFF, 1'b1));
      send_item(data_item(8'h55, 1'b0));
      send_item(data_item(8'hAA, 1'b1));
      send_data_run(2);
   endtask

   task automatic test_single_byte_keys();
      send_item(key_item(8'hFF, 1'b1));
      send_item(data_item(8'h00, 1'b0));
      send_item(data_item(8'hFF, 1'b1));
      // back-to-back schedules
      send_item(key_item(8'h00, 1'b1));
      send_item(key_item(8'h80, 1'b1));
      send_data_run(3);
   endtask

   task automatic test_data_inside_key();
      send_item(key_item(8'h01, 1'b0));
      send_item(key_item(8'hFE, 1'b0));
      send_item(data_item(8'h3C, 1'b0));
      send_item(data_item(8'hC3, 1'b1));
      send_item(key_item(8'h7F, 1'b0));
      send_item(key_item(8'h80, 1'b1));
      send_data_run(2);
   endtask

   task automatic test_full_key();
      send_key(KEY_CAP, 1'b1, 1'b0);
      send_data_run(8);
   endtask

   task automatic test_key_overflow();
      send_key(KEY_CAP + 1, 1'b0, 1'b0);
      // the last-key flag on a dropped byte still starts the schedule
      send_item(key_item(byte_type'($urandom), 1'b1));
      send_data_run(8);
   endtask

   task automatic test_output_stall();
      wait_drained();
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      send_data_run(24);
      req_gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      send_data_run(6);
      wait_drained();
      send_data_run(6);
   endtask

   task automatic test_random_sessions();
      int pick;
      int r;
      int klen;
      while (items_sent < ITEM_TARGET) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         pick        = $urandom_range(0, 99);
         if (pick < 75) begin
            // well-formed: a fresh key, then a buffer of data
            r = $urandom_range(0, 99);
            if (r < 80)      klen = $urandom_range(1, 16);
            else if (r < 95) klen = $urandom_range(17, 64);
            else             klen = $urandom_range(65, KEY_CAP);
            send_key(klen, 1'b1, 1'b1);
            send_data_run($urandom_range(1, 40));
         end else if (pick < 88) begin
            send_data_run($urandom_range(1, 30));
         end else if (pick < 96) begin
            // broken: key left open, data carries on with the old permutation
            send_key($urandom_range(1, 6), 1'b0, 1'b0);
            send_data_run($urandom_range(1, 8));
         end else begin
            wait_drained();
         end
      end
   endtask

   // Response ready: random stalls, or one long hold when asked
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left      = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (stall_left == 0 && rsp_gaps_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap() + 1;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (cipher_q.size() == 0) begin
            note_error($sformatf("unexpected response: out_byte %02h block_end_out %0b",
                                 rsp_chan.payload.out_byte,
                                 rsp_chan.payload.block_end_out));
         end else begin
            want = cipher_q.pop_front();
            if (rsp_chan.payload.out_byte !== want.out_byte)
               note_error($sformatf("response %0d out_byte: expected %02h, got %02h",
                                    results_seen, want.out_byte,
                                    rsp_chan.payload.out_byte));
            if (rsp_chan.payload.block_end_out !== want.block_end_out)
               note_error($sformatf("response %0d block_end_out: expected %0b, got %0b",
                                    results_seen, want.block_end_out,
                                    rsp_chan.payload.block_end_out));
         end
      end
   end

   // Watchdog: stop when no transaction moves for too long
   initial begin
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, cipher_q.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      perm_identity();
      key_len = '0;
      foreach (key_buf[n]) key_buf[n] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_data_before_key();
      test_single_byte_keys();
      test_data_inside_key();
      test_full_key();
      test_key_overflow();
      test_output_stall();
      test_sender_pause();
      test_random_sessions();

      // Drain, then let any schedule still running finish
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (cipher_q.size() != 0)
         note_error($sformatf("%0d responses never arrived", cipher_q.size()));

      $display("covered %0d transactions: %0d key bytes, %0d data bytes, %0d key schedules",
               items_sent, key_items, data_items, schedules_run);
      $display("checked %0d responses, %0d mismatches", results_seen, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
